// ===== rtl/nar_pkg.sv =====
// Shared types and codes for the accumulator refresh block.
// Used by nar_ctrl, nar_weights, nar_accum and the top level.
package nar_pkg;

  // Width of a column / bucket index inside a step (columns and buckets are at most 64)
  localparam int IDX_W = 6;

  // Action codes carried on the input stream
  localparam logic [2:0] ACT_LOAD_W    = 3'd0;
  localparam logic [2:0] ACT_LOAD_BKT  = 3'd1;
  localparam logic [2:0] ACT_LOAD_BIAS = 3'd2;
  localparam logic [2:0] ACT_START     = 3'd3;
  localparam logic [2:0] ACT_ADD       = 3'd4;
  localparam logic [2:0] ACT_READ_COL  = 3'd5;
  localparam logic [2:0] ACT_READ_BKT  = 3'd6;

  // One step issued by the sequencer per cycle
  typedef enum logic [3:0] {
    ST_NONE,
    ST_LD_W,
    ST_LD_BKT,
    ST_LD_BIAS,
    ST_COL_INIT,
    ST_COL_ADD,
    ST_BKT_CLR,
    ST_BKT_ADD,
    ST_COL_RD,
    ST_BKT_RD
  } step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    logic             side;
    logic [IDX_W-1:0] idx;
  } step_t;

  // Sign-extend a 16-bit column sum to 32 bits
  function automatic logic [31:0] widen16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ===== rtl/nar_ctrl.sv =====
// Sequencer: takes one beat, decodes the action and issues one step per cycle.
// Depends on nar_pkg.
module nar_ctrl #(
  parameter int FEATURE_COUNT = 4096,
  parameter int ACC_WIDTH     = 64,
  parameter int BUCKET_COUNT  = 8,
  parameter int WAW           = 18,
  parameter int BAW           = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [2:0]         action,
  input  logic               side,
  input  logic [15:0]        fi,
  input  logic [5:0]         col,
  input  logic [31:0]        val,
  output logic               ready,
  output nar_pkg::step_t     step,
  output logic [WAW-1:0]     wbase,
  output logic [BAW-1:0]     bbase,
  output logic [31:0]        wdata,
  input  logic [31:0]        rd_value,
  input  logic               out_free,
  output logic               res_push,
  output logic [31:0]        res_value,
  output logic               res_err
);
  import nar_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_LOAD, S_WALK, S_DRAIN, S_RD, S_RD_WAIT, S_RESP
  } state_t;

  state_t           state;
  logic [2:0]       act;
  logic             side_r;
  logic [15:0]      fi_r;
  logic [5:0]       col_r;
  logic             fi_ok;
  logic             col_ok;
  logic             bkt_ok;
  logic [IDX_W-1:0] cnt;
  logic             bkt_phase;

  // Step issued in the current state
  always_comb begin
    step = '{kind: ST_NONE, side: side_r, idx: '0};
    case (state)
      S_LOAD: begin
        step.idx = col_r;
        if (act == ACT_LOAD_W) begin
          step.kind = ST_LD_W;
        end else if (act == ACT_LOAD_BKT) begin
          step.kind = ST_LD_BKT;
        end else begin
          step.kind = ST_LD_BIAS;
        end
      end
      S_WALK: begin
        step.idx = cnt;
        if (!bkt_phase) begin
          step.kind = (act == ACT_START) ? ST_COL_INIT : ST_COL_ADD;
        end else begin
          step.kind = (act == ACT_START) ? ST_BKT_CLR : ST_BKT_ADD;
        end
      end
      S_RD: begin
        step.idx  = col_r;
        step.kind = (act == ACT_READ_COL) ? ST_COL_RD : ST_BKT_RD;
      end
      default: begin
        step.kind = ST_NONE;
      end
    endcase
  end

  assign ready    = (state == S_IDLE);
  assign res_push = (state == S_RESP) && out_free;

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            act    <= action;
            side_r <= side;
            fi_r   <= fi;
            col_r  <= col;
            wdata  <= val;
            fi_ok  <= ({1'b0, fi} < 17'(FEATURE_COUNT));
            col_ok <= ({1'b0, col} < 7'(ACC_WIDTH));
            bkt_ok <= ({1'b0, col} < 7'(BUCKET_COUNT));
            state  <= S_SETUP;
          end
        end
        S_SETUP: begin
          // row bases for both weight stores
          wbase     <= WAW'(fi_r * ACC_WIDTH);
          bbase     <= BAW'(fi_r * BUCKET_COUNT);
          cnt       <= '0;
          bkt_phase <= 1'b0;
          res_value <= '0;
          res_err   <= 1'b0;
          case (act)
            ACT_LOAD_W:    state <= (fi_ok && col_ok) ? S_LOAD : S_IDLE;
            ACT_LOAD_BKT:  state <= (fi_ok && bkt_ok) ? S_LOAD : S_IDLE;
            ACT_LOAD_BIAS: state <= col_ok ? S_LOAD : S_IDLE;
            ACT_START:     state <= S_WALK;
            ACT_ADD: begin
              if (fi_ok) begin
                state <= S_WALK;
              end else begin
                res_err <= 1'b1;
                state   <= S_RESP;
              end
            end
            ACT_READ_COL:  state <= col_ok ? S_RD : S_RESP;
            ACT_READ_BKT:  state <= bkt_ok ? S_RD : S_RESP;
            default:       state <= S_IDLE;
          endcase
        end
        S_LOAD: begin
          state <= S_IDLE;
        end
        S_WALK: begin
          // columns first, then buckets
          if (!bkt_phase) begin
            if (cnt == IDX_W'(ACC_WIDTH - 1)) begin
              bkt_phase <= 1'b1;
              cnt       <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end else begin
            if (cnt == IDX_W'(BUCKET_COUNT - 1)) begin
              state <= S_DRAIN;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_DRAIN: begin
          // last write-back lands this cycle
          state <= (act == ACT_ADD) ? S_RESP : S_IDLE;
        end
        S_RD: begin
          state <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          res_value <= rd_value;
          state     <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/nar_weights.sv =====
// Weight, bucket weight and bias memories with registered read ports.
// Depends on nar_pkg; driven by steps from nar_ctrl.
module nar_weights #(
  parameter int FEATURE_COUNT = 4096,
  parameter int ACC_WIDTH     = 64,
  parameter int BUCKET_COUNT  = 8,
  parameter int WAW           = 18,
  parameter int BAW           = 15,
  parameter int CW            = 6
) (
  input  logic           clk,
  input  nar_pkg::step_t step,
  input  logic [WAW-1:0] wbase,
  input  logic [BAW-1:0] bbase,
  input  logic [31:0]    wdata,
  output logic [15:0]    w_q,
  output logic [31:0]    bw_q,
  output logic [15:0]    bias_q
);
  import nar_pkg::*;

  localparam int WDEPTH    = FEATURE_COUNT * ACC_WIDTH;
  localparam int BDEPTH    = FEATURE_COUNT * BUCKET_COUNT;
  localparam int BIAS_DEPTH = 2 ** CW;

  logic [15:0] w_mem    [WDEPTH];
  logic [31:0] bw_mem   [BDEPTH];
  logic [15:0] bias_mem [BIAS_DEPTH];

  logic [WAW-1:0] waddr;
  logic [BAW-1:0] baddr;
  logic [CW-1:0]  cidx;

  assign waddr = wbase + WAW'(step.idx);
  assign baddr = bbase + BAW'(step.idx);
  assign cidx  = step.idx[CW-1:0];

  // Feature weight rows
  always_ff @(posedge clk) begin
    if (step.kind == ST_LD_W) begin
      w_mem[waddr] <= wdata[15:0];
    end
    w_q <= w_mem[waddr];
  end

  // Bucket weight rows
  always_ff @(posedge clk) begin
    if (step.kind == ST_LD_BKT) begin
      bw_mem[baddr] <= wdata;
    end
    bw_q <= bw_mem[baddr];
  end

  // Biases
  always_ff @(posedge clk) begin
    if (step.kind == ST_LD_BIAS) begin
      bias_mem[cidx] <= wdata[15:0];
    end
    bias_q <= bias_mem[cidx];
  end

endmodule

// ===== rtl/nar_accum.sv =====
// Column and bucket sum memories for both sides, with the shared 32-bit adder.
// Depends on nar_pkg; reads operands from nar_weights in the cycle after each step.
module nar_accum #(
  parameter int CW  = 6,
  parameter int BKW = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  nar_pkg::step_t step,
  input  logic [15:0]    w_q,
  input  logic [31:0]    bw_q,
  input  logic [15:0]    bias_q,
  output logic [31:0]    rd_value
);
  import nar_pkg::*;

  localparam int CD = 2 ** (CW + 1);
  localparam int BD = 2 ** (BKW + 1);

  logic [15:0]   col_mem [CD];
  logic [31:0]   bkt_mem [BD];
  logic [CD-1:0] col_vld;
  logic [BD-1:0] bkt_vld;

  step_t         p1;
  logic [15:0]   col_q;
  logic [31:0]   bkt_q;
  logic          col_vq;
  logic          bkt_vq;

  logic [CW:0]   col_raddr;
  logic [BKW:0]  bkt_raddr;
  logic [CW:0]   col_waddr;
  logic [BKW:0]  bkt_waddr;
  logic [15:0]   col_cur;
  logic [31:0]   bkt_cur;
  logic [31:0]   op_a;
  logic [31:0]   op_b;
  logic [31:0]   sum;
  logic          col_we;
  logic          bkt_we;

  assign col_raddr = {step.side, step.idx[CW-1:0]};
  assign bkt_raddr = {step.side, step.idx[BKW-1:0]};
  assign col_waddr = {p1.side, p1.idx[CW-1:0]};
  assign bkt_waddr = {p1.side, p1.idx[BKW-1:0]};

  // entries never written since reset read as zero
  assign col_cur = col_vq ? col_q : 16'h0000;
  assign bkt_cur = bkt_vq ? bkt_q : 32'h0000_0000;

  assign col_we = (p1.kind == ST_COL_INIT) || (p1.kind == ST_COL_ADD);
  assign bkt_we = (p1.kind == ST_BKT_CLR) || (p1.kind == ST_BKT_ADD);

  // Shared adder operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (p1.kind)
      ST_COL_INIT: op_b = {16'h0000, bias_q};
      ST_COL_ADD: begin
        op_a = {16'h0000, col_cur};
        op_b = {16'h0000, w_q};
      end
      ST_BKT_ADD: begin
        op_a = bkt_cur;
        op_b = bw_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sum = op_a + op_b;

  // Read result for the output
  always_comb begin
    case (p1.kind)
      ST_COL_RD: rd_value = widen16(col_cur);
      ST_BKT_RD: rd_value = bkt_cur;
      default:   rd_value = '0;
    endcase
  end

  // Pipeline step and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1      <= '{kind: ST_NONE, side: 1'b0, idx: '0};
      col_vld <= '0;
      bkt_vld <= '0;
    end else begin
      p1     <= step;
      col_vq <= col_vld[col_raddr];
      bkt_vq <= bkt_vld[bkt_raddr];
      if (col_we) begin
        col_vld[col_waddr] <= 1'b1;
      end
      if (bkt_we) begin
        bkt_vld[bkt_waddr] <= 1'b1;
      end
    end
  end

  // Sum memories: read at the issued step, write back in the cycle after
  always_ff @(posedge clk) begin
    col_q <= col_mem[col_raddr];
    bkt_q <= bkt_mem[bkt_raddr];
    if (col_we) begin
      col_mem[col_waddr] <= sum[15:0];
    end
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= sum;
    end
  end

endmodule

// ===== rtl/nnue_accumulator_refresh_core.sv =====
// Top level of the accumulator refresh block: stream ports and output register.
// Depends on nar_pkg, nar_ctrl, nar_weights and nar_accum.
//
// Feature transformer accumulator for two sides. One beat is taken at a time; s_tready
// is low until the beat is done. Loads out of range are ignored, and a beat that gives a
// result waits on the output register; a read out of range returns zero. For start and
// add, a single 32-bit adder walks every column and then every bucket of the selected
// side, one per cycle, reading the sum and weight memories in the cycle before the
// write-back. Add, read column and read bucket beats each give one result beat; loads
// and start give none. An add whose index is not below FEATURE_COUNT is skipped and
// reports index_error. A finished result sits in the output register while the next
// beat is taken. Sums reset to zero through per-entry valid bits, so no clearing pass
// is needed after reset.
module nnue_accumulator_refresh_core #(
  parameter int FEATURE_COUNT = 4096,
  parameter int ACC_WIDTH     = 64,
  parameter int BUCKET_COUNT  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // feature_index[15:0], column[21:16], load_value[53:22]
  input  logic [3:0]  s_tuser,   // action[2:0], perspective[3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // read_value[31:0], index_error[32]
);
  import nar_pkg::*;

  localparam int WDEPTH = FEATURE_COUNT * ACC_WIDTH;
  localparam int BDEPTH = FEATURE_COUNT * BUCKET_COUNT;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int CW     = (ACC_WIDTH > 1) ? $clog2(ACC_WIDTH) : 1;
  localparam int BKW    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  logic           in_fire;
  logic           out_free;
  step_t          step;
  logic [WAW-1:0] wbase;
  logic [BAW-1:0] bbase;
  logic [31:0]    wdata;
  logic [15:0]    w_q;
  logic [31:0]    bw_q;
  logic [15:0]    bias_q;
  logic [31:0]    rd_value;
  logic           res_push;
  logic [31:0]    res_value;
  logic           res_err;
  logic [31:0]    out_value;
  logic           out_err;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  nar_ctrl #(
    .FEATURE_COUNT (FEATURE_COUNT),
    .ACC_WIDTH     (ACC_WIDTH),
    .BUCKET_COUNT  (BUCKET_COUNT),
    .WAW           (WAW),
    .BAW           (BAW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .action    (s_tuser[2:0]),
    .side      (s_tuser[3]),
    .fi        (s_tdata[15:0]),
    .col       (s_tdata[21:16]),
    .val       (s_tdata[53:22]),
    .ready     (s_tready),
    .step      (step),
    .wbase     (wbase),
    .bbase     (bbase),
    .wdata     (wdata),
    .rd_value  (rd_value),
    .out_free  (out_free),
    .res_push  (res_push),
    .res_value (res_value),
    .res_err   (res_err)
  );

  nar_weights #(
    .FEATURE_COUNT (FEATURE_COUNT),
    .ACC_WIDTH     (ACC_WIDTH),
    .BUCKET_COUNT  (BUCKET_COUNT),
    .WAW           (WAW),
    .BAW           (BAW),
    .CW            (CW)
  ) u_weights (
    .clk    (clk),
    .step   (step),
    .wbase  (wbase),
    .bbase  (bbase),
    .wdata  (wdata),
    .w_q    (w_q),
    .bw_q   (bw_q),
    .bias_q (bias_q)
  );

  nar_accum #(
    .CW  (CW),
    .BKW (BKW)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .w_q      (w_q),
    .bw_q     (bw_q),
    .bias_q   (bias_q),
    .rd_value (rd_value)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_push) begin
      m_tvalid  <= 1'b1;
      out_value <= res_value;
      out_err   <= res_err;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {7'b0000000, out_err, out_value};

`ifndef SYNTHESIS
  // a result never overwrites one that is still waiting
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (!m_tvalid || m_tready))
    else $error("result pushed into a full output register");

  // the block is busy for at least the cycle after a beat is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("input taken twice in a row");

  // no step is issued while waiting for input
  a_idle_no_step: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (step.kind == ST_NONE))
    else $error("step issued while idle");

  // a result is only pushed while a beat is in work
  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !s_tready)
    else $error("result pushed while idle");
`endif

endmodule
